// ===== rtl/core/fnorm_pkg.sv =====
// Shared types for the fraction normalizer core.
package fnorm_pkg;

  typedef enum logic {
    SEL_GCD,
    SEL_DIV
  } sub_sel_t;

endpackage

// ===== rtl/core/fraction_normalizer_core.sv =====
// Fraction normalizer core: reduces a signed fraction by the gcd of its parts.
//
// Channel  Direction  Handshake                Word
// in       input      start high, busy low     in_numerator_in, in_denominator_in
// out      output     out_strobe, one cycle    out_numerator_out, out_denominator_out,
//                                              out_zero_denominator
//
// A zero denominator gives its result strobe in the cycle after the word is taken.
// Any other word runs binary gcd steps until one operand is zero and a step to see the
// end, then rescaling steps for the common power of two and a step to load the divider,
// then two restoring divisions by the gcd: the numerator first, then the denominator.
// Reset is synchronous and active low; it clears the sequencer and the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fraction_normalizer_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_numerator_in,
  input  logic signed [DATA_WIDTH-1:0] in_denominator_in,
  output logic                         out_strobe,
  output logic signed [DATA_WIDTH-1:0] out_numerator_out,
  output logic signed [DATA_WIDTH-1:0] out_denominator_out,
  output logic                         out_zero_denominator
);
  import fnorm_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int KW = $clog2(W);
  localparam logic [KW-1:0] LAST_CNT = KW'(W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SCALE,
    ST_DIVN,
    ST_DIVD
  } state_t;

  state_t        state_r, state_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  g_r, g_nxt;
  logic [W-1:0]  mn_r, mn_nxt;
  logic [W-1:0]  md_r, md_nxt;
  logic [W-1:0]  rn_r, rn_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          strobe_r, strobe_nxt;
  logic [W-1:0]  num_out_r, num_out_nxt;
  logic [W-1:0]  den_out_r, den_out_nxt;
  logic          zd_r, zd_nxt;

  logic [W-1:0]  in_num_mag;
  logic [W-1:0]  in_den_mag;
  logic [W-1:0]  rem_sh;
  logic [W-1:0]  quot;
  logic [W-1:0]  sub_diff;
  logic          sub_borrow;
  sub_sel_t      sub_sel;

  assign in_num_mag = in_numerator_in[W-1] ? (~in_numerator_in + 1'b1) : in_numerator_in;
  assign in_den_mag = in_denominator_in[W-1] ? (~in_denominator_in + 1'b1)
                                             : in_denominator_in;
  assign rem_sh     = {b_r[W-2:0], a_r[W-1]};
  assign quot       = {a_r[W-2:0], ~sub_borrow};
  assign sub_sel    = (state_r == ST_GCD) ? SEL_GCD : SEL_DIV;

  fnorm_sub #(
    .W (W)
  ) u_sub (
    .sel     (sub_sel),
    .gcd_a   (a_r),
    .gcd_b   (b_r),
    .div_rem (rem_sh),
    .div_g   (g_r),
    .diff    (sub_diff),
    .borrow  (sub_borrow)
  );

  always_comb begin
    state_nxt   = state_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    g_nxt       = g_r;
    mn_nxt      = mn_r;
    md_nxt      = md_r;
    rn_nxt      = rn_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    neg_nxt     = neg_r;
    strobe_nxt  = 1'b0;
    num_out_nxt = num_out_r;
    den_out_nxt = den_out_r;
    zd_nxt      = zd_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_denominator_in == '0) begin
            num_out_nxt = in_numerator_in;
            den_out_nxt = '0;
            zd_nxt      = 1'b1;
            strobe_nxt  = 1'b1;
          end else begin
            a_nxt     = in_num_mag;
            b_nxt     = in_den_mag;
            mn_nxt    = in_num_mag;
            md_nxt    = in_den_mag;
            neg_nxt   = (in_numerator_in != '0) &&
                        (in_numerator_in[W-1] != in_denominator_in[W-1]);
            k_nxt     = '0;
            state_nxt = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (a_r == '0) begin
          state_nxt = ST_SCALE;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (sub_borrow) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = sub_diff >> 1;
        end
      end
      ST_SCALE: begin
        if (k_r == '0) begin
          g_nxt     = b_r;
          a_nxt     = mn_r;
          b_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIVN;
        end else begin
          b_nxt = b_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end
      ST_DIVN: begin
        a_nxt   = quot;
        b_nxt   = sub_borrow ? rem_sh : sub_diff;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          rn_nxt    = quot;
          a_nxt     = md_r;
          b_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIVD;
        end
      end
      ST_DIVD: begin
        a_nxt   = quot;
        b_nxt   = sub_borrow ? rem_sh : sub_diff;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          num_out_nxt = neg_r ? (~rn_r + 1'b1) : rn_r;
          den_out_nxt = quot;
          zd_nxt      = 1'b0;
          strobe_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    g_r       <= g_nxt;
    mn_r      <= mn_nxt;
    md_r      <= md_nxt;
    rn_r      <= rn_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    num_out_r <= num_out_nxt;
    den_out_r <= den_out_nxt;
    zd_r      <= zd_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_strobe           = strobe_r;
  assign out_numerator_out    = num_out_r;
  assign out_denominator_out  = den_out_r;
  assign out_zero_denominator = zd_r;

`ifndef NO_ASSERTIONS
  a_done_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe)
    else $error("Sequencer went idle without a result strobe.");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("Result strobe while the sequencer is still busy.");

  a_zero_den_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_zero_denominator |-> out_denominator_out == '0)
    else $error("Zero denominator flag with a nonzero denominator.");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_denominator_in != '0) |=> busy && !out_strobe)
    else $error("Nonzero denominator word did not start the sequencer.");
`endif

endmodule

// ===== rtl/core/fnorm_sub.sv =====
// Shared subtractor used for the gcd steps and the restoring division steps.
module fnorm_sub #(
  parameter int W = 32
) (
  input  fnorm_pkg::sub_sel_t sel,
  input  logic [W-1:0]        gcd_a,
  input  logic [W-1:0]        gcd_b,
  input  logic [W-1:0]        div_rem,
  input  logic [W-1:0]        div_g,
  output logic [W-1:0]        diff,
  output logic                borrow
);
  import fnorm_pkg::*;

  logic [W-1:0] op_a;
  logic [W-1:0] op_b;
  logic [W:0]   full;

  always_comb begin
    case (sel)
      SEL_GCD: begin
        op_a = gcd_a;
        op_b = gcd_b;
      end
      default: begin
        op_a = div_rem;
        op_b = div_g;
      end
    endcase
  end

  assign full   = {1'b0, op_a} - {1'b0, op_b};
  assign diff   = full[W-1:0];
  assign borrow = full[W];

endmodule
